[hw/rtl/cnp_pkg.sv]
`default_nettype none
package cnp_pkg;

	localparam int SQRT_CELLS = 32;
	localparam int DIV_CELLS  = 15;

	localparam logic signed [15:0] ONE_Q14   = 16'sd16384;
	localparam logic [14:0]        ONE_Q14_U = 15'd16384;

	typedef struct packed {
		logic                hit;
		logic                swapped;
		logic                round;
		logic                zero;
		logic                neg_x;
		logic                neg_y;
		logic                half;
		logic [31:0]         r;
		logic [31:0]         pen;
		logic signed [15:0]  box_nx;
		logic signed [15:0]  box_ny;
		logic [31:0]         ax;
		logic [31:0]         ay;
	} cnp_ctx_t;

endpackage
`default_nettype wire

[hw/rtl/cnp_front.sv]
`default_nettype none
module cnp_front import cnp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               valid_in,
	input  wire logic               first_is_box,
	input  wire logic signed [31:0] first_x,
	input  wire logic signed [31:0] first_y,
	input  wire logic [30:0]        first_extent_w,
	input  wire logic [30:0]        first_extent_h,
	input  wire logic               second_is_box,
	input  wire logic signed [31:0] second_x,
	input  wire logic signed [31:0] second_y,
	input  wire logic [30:0]        second_extent_w,
	input  wire logic [30:0]        second_extent_h,
	output logic                    valid_out,
	output cnp_ctx_t                ctx_out,
	output logic [63:0]             sum_out
);

	logic signed [34:0] fx2, fy2, sx2, sy2, fw, fh, sw, sh;
	logic signed [34:0] cir_x, cir_y, box_x, box_y, box_w, box_h;
	logic signed [34:0] lo_x, hi_x, lo_y, hi_y, clx, cly, pxc, pyc;
	logic [30:0]        rad;
	logic signed [35:0] dcb_x, dcb_y, dcc_x, dcc_y;
	logic signed [34:0] a_l, a_r, a_b, a_t, b_l, b_r, b_b, b_t;
	logic signed [35:0] ox1, ox2, oy1, oy2, ovx, ovy, ovm;
	logic               cc, sep;
	cnp_ctx_t           ctx_c;
	cnp_ctx_t           ctx_c2, ctx_c4;

	logic               v_s1, v_s2, v_s3, v_s4;
	cnp_ctx_t           ctx_s1, ctx_s2, ctx_s3, ctx_s4;
	logic signed [35:0] dx_s1, dy_s1;
	logic [35:0]        absx, absy;
	logic               pre_s2, pre_s3;
	logic [63:0]        sx_s3, sy_s3, rr_s3;
	logic [64:0]        sum;
	logic [63:0]        sum_s4;

	always_comb begin
		fx2 = $signed({first_x[31], first_x, 1'b0});
		fy2 = $signed({first_y[31], first_y, 1'b0});
		sx2 = $signed({second_x[31], second_x, 1'b0});
		sy2 = $signed({second_y[31], second_y, 1'b0});
		fw  = $signed({4'b0, first_extent_w});
		fh  = $signed({4'b0, first_extent_h});
		sw  = $signed({4'b0, second_extent_w});
		sh  = $signed({4'b0, second_extent_h});

		cir_x = first_is_box ? sx2 : fx2;
		cir_y = first_is_box ? sy2 : fy2;
		box_x = first_is_box ? fx2 : sx2;
		box_y = first_is_box ? fy2 : sy2;
		box_w = first_is_box ? fw : sw;
		box_h = first_is_box ? fh : sh;
		rad   = first_is_box ? second_extent_w : first_extent_w;
		lo_x  = box_x - box_w;
		hi_x  = box_x + box_w;
		lo_y  = box_y - box_h;
		hi_y  = box_y + box_h;
		clx   = (cir_x < hi_x) ? cir_x : hi_x;
		pxc   = (clx < lo_x) ? lo_x : clx;
		cly   = (cir_y < hi_y) ? cir_y : hi_y;
		pyc   = (cly < lo_y) ? lo_y : cly;
		dcb_x = $signed({cir_x[34], cir_x}) - $signed({pxc[34], pxc});
		dcb_y = $signed({cir_y[34], cir_y}) - $signed({pyc[34], pyc});

		dcc_x = $signed({{4{second_x[31]}}, second_x}) - $signed({{4{first_x[31]}}, first_x});
		dcc_y = $signed({{4{second_y[31]}}, second_y}) - $signed({{4{first_y[31]}}, first_y});

		a_l = fx2 - fw;
		a_r = fx2 + fw;
		a_b = fy2 - fh;
		a_t = fy2 + fh;
		b_l = sx2 - sw;
		b_r = sx2 + sw;
		b_b = sy2 - sh;
		b_t = sy2 + sh;
		sep = (a_r < b_l) || (a_l > b_r) || (a_t < b_b) || (a_b > b_t);
		ox1 = $signed({a_r[34], a_r}) - $signed({b_l[34], b_l});
		ox2 = $signed({b_r[34], b_r}) - $signed({a_l[34], a_l});
		oy1 = $signed({a_t[34], a_t}) - $signed({b_b[34], b_b});
		oy2 = $signed({b_t[34], b_t}) - $signed({a_b[34], a_b});
		ovx = (ox1 < ox2) ? ox1 : ox2;
		ovy = (oy1 < oy2) ? oy1 : oy2;
		ovm = (ovx < ovy) ? ovx : ovy;

		cc = !first_is_box && !second_is_box;

		ctx_c         = '0;
		ctx_c.round   = !(first_is_box && second_is_box);
		ctx_c.swapped = first_is_box && !second_is_box;
		ctx_c.half    = !cc;
		ctx_c.r       = cc ? (32'(first_extent_w) + 32'(second_extent_w)) : {rad, 1'b0};
		ctx_c.hit     = !sep;
		ctx_c.pen     = ovm[32:1];
		if (ovx < ovy) begin
			ctx_c.box_nx = (first_x < second_x) ? -ONE_Q14 : ONE_Q14;
		end else begin
			ctx_c.box_ny = (first_y < second_y) ? -ONE_Q14 : ONE_Q14;
		end
	end

	always_comb begin
		absx = dx_s1[35] ? 36'(-dx_s1) : 36'(dx_s1);
		absy = dy_s1[35] ? 36'(-dy_s1) : 36'(dy_s1);
		sum  = {1'b0, sx_s3} + {1'b0, sy_s3};

		ctx_c2       = ctx_s1;
		ctx_c2.neg_x = dx_s1[35];
		ctx_c2.neg_y = dy_s1[35];
		ctx_c2.ax    = absx[31:0];
		ctx_c2.ay    = absy[31:0];

		ctx_c4      = ctx_s3;
		ctx_c4.hit  = ctx_s3.round ? (pre_s3 && (sum < {1'b0, rr_s3})) : ctx_s3.hit;
		ctx_c4.zero = (sum == 65'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid_in;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1 <= ctx_c;
			dx_s1  <= cc ? dcc_x : dcb_x;
			dy_s1  <= cc ? dcc_y : dcb_y;

			ctx_s2 <= ctx_c2;
			pre_s2 <= (absx < {4'b0, ctx_s1.r}) && (absy < {4'b0, ctx_s1.r});

			ctx_s3 <= ctx_s2;
			pre_s3 <= pre_s2;
			sx_s3  <= ctx_s2.ax * ctx_s2.ax;
			sy_s3  <= ctx_s2.ay * ctx_s2.ay;
			rr_s3  <= ctx_s2.r * ctx_s2.r;

			ctx_s4 <= ctx_c4;
			sum_s4 <= sum[63:0];
		end
	end

	assign valid_out = v_s4;
	assign ctx_out   = ctx_s4;
	assign sum_out   = sum_s4;

endmodule
`default_nettype wire

[hw/rtl/cnp_sqrt_cell.sv]
`default_nettype none
module cnp_sqrt_cell import cnp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        valid_in,
	input  wire cnp_ctx_t    ctx_in,
	input  wire logic [33:0] rem_in,
	input  wire logic [31:0] root_in,
	input  wire logic [63:0] val_in,
	output logic             valid_out,
	output cnp_ctx_t         ctx_out,
	output logic [33:0]      rem_out,
	output logic [31:0]      root_out,
	output logic [63:0]      val_out
);

	logic [35:0] cur, trial, diff;
	logic        ge;

	always_comb begin
		cur   = {rem_in, val_in[63:62]};
		trial = {2'b0, root_in, 2'b01};
		diff  = cur - trial;
		ge    = (cur >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_out  <= ctx_in;
			rem_out  <= ge ? diff[33:0] : cur[33:0];
			root_out <= {root_in[30:0], ge};
			val_out  <= {val_in[61:0], 2'b00};
		end
	end

endmodule
`default_nettype wire

[hw/rtl/cnp_div_cell.sv]
`default_nettype none
module cnp_div_cell import cnp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire logic        valid_in,
	input  wire cnp_ctx_t    ctx_in,
	input  wire logic [31:0] div_in,
	input  wire logic [31:0] rx_in,
	input  wire logic [31:0] ry_in,
	input  wire logic [14:0] nx_in,
	input  wire logic [14:0] ny_in,
	input  wire logic [14:0] qx_in,
	input  wire logic [14:0] qy_in,
	output logic             valid_out,
	output cnp_ctx_t         ctx_out,
	output logic [31:0]      div_out,
	output logic [31:0]      rx_out,
	output logic [31:0]      ry_out,
	output logic [14:0]      nx_out,
	output logic [14:0]      ny_out,
	output logic [14:0]      qx_out,
	output logic [14:0]      qy_out
);

	logic [32:0] cur_x, cur_y, dif_x, dif_y;
	logic        ge_x, ge_y;

	always_comb begin
		cur_x = {rx_in, nx_in[14]};
		cur_y = {ry_in, ny_in[14]};
		dif_x = cur_x - {1'b0, div_in};
		dif_y = cur_y - {1'b0, div_in};
		ge_x  = (cur_x >= {1'b0, div_in});
		ge_y  = (cur_y >= {1'b0, div_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_out <= 1'b0;
		end else if (en) begin
			valid_out <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_out <= ctx_in;
			div_out <= div_in;
			rx_out  <= ge_x ? dif_x[31:0] : cur_x[31:0];
			ry_out  <= ge_y ? dif_y[31:0] : cur_y[31:0];
			nx_out  <= {nx_in[13:0], 1'b0};
			ny_out  <= {ny_in[13:0], 1'b0};
			qx_out  <= {qx_in[13:0], ge_x};
			qy_out  <= {qy_in[13:0], ge_y};
		end
	end

endmodule
`default_nettype wire

[hw/rtl/collision_2d_circle_box_narrowphase_top.sv]
// Narrowphase contact test for pairs of 2D circles and axis-aligned boxes.
// Request channel: req_valid / req_stall with the two bodies' fields. A request
// is taken at a rising edge with req_valid high and req_stall low.
// Response channel: rsp_valid / rsp_stall with hit, penetration, the Q2.14
// normal and order_swapped. One response per request, in request order.
// Throughput: one pair per cycle while rsp_stall does not hold the chain. Most
// of the depth comes from the 32-cell square-root chain (one root bit per
// cell) and the 15-cell divider chain (one normal quotient bit per cell).
// Front stages: difference and clamp, magnitude check, squares, sum.
// When the response is held by rsp_stall the whole chain holds and req_stall
// rises; while the output register is empty the chain keeps moving.
// Reset clears all valid bits; no response is pending after reset.
`default_nettype none
module collision_2d_circle_box_narrowphase_top import cnp_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_stall,
	input  wire logic               first_is_box,
	input  wire logic signed [31:0] first_x,
	input  wire logic signed [31:0] first_y,
	input  wire logic [30:0]        first_extent_w,
	input  wire logic [30:0]        first_extent_h,
	input  wire logic               second_is_box,
	input  wire logic signed [31:0] second_x,
	input  wire logic signed [31:0] second_y,
	input  wire logic [30:0]        second_extent_w,
	input  wire logic [30:0]        second_extent_h,
	output logic                    rsp_valid,
	input  wire logic               rsp_stall,
	output logic                    hit,
	output logic [31:0]             penetration,
	output logic signed [15:0]      normal_x,
	output logic signed [15:0]      normal_y,
	output logic                    order_swapped
);

	logic        en;
	logic        sq_v    [0:SQRT_CELLS];
	cnp_ctx_t    sq_ctx  [0:SQRT_CELLS];
	logic [33:0] sq_rem  [0:SQRT_CELLS];
	logic [31:0] sq_root [0:SQRT_CELLS];
	logic [63:0] sq_val  [0:SQRT_CELLS];

	logic        dv_v    [0:DIV_CELLS];
	cnp_ctx_t    dv_ctx  [0:DIV_CELLS];
	logic [31:0] dv_div  [0:DIV_CELLS];
	logic [31:0] dv_rx   [0:DIV_CELLS];
	logic [31:0] dv_ry   [0:DIV_CELLS];
	logic [14:0] dv_nx   [0:DIV_CELLS];
	logic [14:0] dv_ny   [0:DIV_CELLS];
	logic [14:0] dv_qx   [0:DIV_CELLS];
	logic [14:0] dv_qy   [0:DIV_CELLS];

	logic [31:0] s;
	logic [46:0] num_x, num_y;
	logic [31:0] rdiff;
	cnp_ctx_t    ctx_n;
	logic        v_s5;
	cnp_ctx_t    ctx_s5;
	logic [31:0] s_s5;
	logic [46:0] numx_s5, numy_s5;

	cnp_ctx_t           fc;
	logic [14:0]        qx, qy;
	logic signed [15:0] nxv, nyv;

	assign en        = !rsp_valid || !rsp_stall;
	assign req_stall = !en;

	cnp_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en),
		.valid_in        (req_valid),
		.first_is_box    (first_is_box),
		.first_x         (first_x),
		.first_y         (first_y),
		.first_extent_w  (first_extent_w),
		.first_extent_h  (first_extent_h),
		.second_is_box   (second_is_box),
		.second_x        (second_x),
		.second_y        (second_y),
		.second_extent_w (second_extent_w),
		.second_extent_h (second_extent_h),
		.valid_out       (sq_v[0]),
		.ctx_out         (sq_ctx[0]),
		.sum_out         (sq_val[0])
	);

	assign sq_rem[0]  = '0;
	assign sq_root[0] = '0;

	for (genvar i = 0; i < SQRT_CELLS; i++) begin : g_sqrt
		cnp_sqrt_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (sq_v[i]),
			.ctx_in    (sq_ctx[i]),
			.rem_in    (sq_rem[i]),
			.root_in   (sq_root[i]),
			.val_in    (sq_val[i]),
			.valid_out (sq_v[i+1]),
			.ctx_out   (sq_ctx[i+1]),
			.rem_out   (sq_rem[i+1]),
			.root_out  (sq_root[i+1]),
			.val_out   (sq_val[i+1])
		);
	end

	always_comb begin
		s     = sq_root[SQRT_CELLS];
		num_x = {1'b0, sq_ctx[SQRT_CELLS].ax, 14'b0} + {16'b0, s[31:1]};
		num_y = {1'b0, sq_ctx[SQRT_CELLS].ay, 14'b0} + {16'b0, s[31:1]};
		rdiff = sq_ctx[SQRT_CELLS].r - s;
		ctx_n = sq_ctx[SQRT_CELLS];
		if (ctx_n.round) begin
			ctx_n.pen = ctx_n.half ? {1'b0, rdiff[31:1]} : rdiff;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= sq_v[SQRT_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s5  <= ctx_n;
			s_s5    <= s;
			numx_s5 <= num_x;
			numy_s5 <= num_y;
		end
	end

	assign dv_v[0]   = v_s5;
	assign dv_ctx[0] = ctx_s5;
	assign dv_div[0] = s_s5;
	assign dv_rx[0]  = numx_s5[46:15];
	assign dv_ry[0]  = numy_s5[46:15];
	assign dv_nx[0]  = numx_s5[14:0];
	assign dv_ny[0]  = numy_s5[14:0];
	assign dv_qx[0]  = '0;
	assign dv_qy[0]  = '0;

	for (genvar j = 0; j < DIV_CELLS; j++) begin : g_div
		cnp_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.valid_in  (dv_v[j]),
			.ctx_in    (dv_ctx[j]),
			.div_in    (dv_div[j]),
			.rx_in     (dv_rx[j]),
			.ry_in     (dv_ry[j]),
			.nx_in     (dv_nx[j]),
			.ny_in     (dv_ny[j]),
			.qx_in     (dv_qx[j]),
			.qy_in     (dv_qy[j]),
			.valid_out (dv_v[j+1]),
			.ctx_out   (dv_ctx[j+1]),
			.div_out   (dv_div[j+1]),
			.rx_out    (dv_rx[j+1]),
			.ry_out    (dv_ry[j+1]),
			.nx_out    (dv_nx[j+1]),
			.ny_out    (dv_ny[j+1]),
			.qx_out    (dv_qx[j+1]),
			.qy_out    (dv_qy[j+1])
		);
	end

	always_comb begin
		fc  = dv_ctx[DIV_CELLS];
		qx  = (dv_qx[DIV_CELLS] > ONE_Q14_U) ? ONE_Q14_U : dv_qx[DIV_CELLS];
		qy  = (dv_qy[DIV_CELLS] > ONE_Q14_U) ? ONE_Q14_U : dv_qy[DIV_CELLS];
		nxv = fc.neg_x ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
		nyv = fc.neg_y ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
		if (fc.round && fc.zero) begin
			nxv = ONE_Q14;
			nyv = '0;
		end else if (!fc.round) begin
			nxv = fc.box_nx;
			nyv = fc.box_ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (en) begin
			rsp_valid <= dv_v[DIV_CELLS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit           <= fc.hit;
			penetration   <= fc.hit ? fc.pen : '0;
			normal_x      <= fc.hit ? nxv : '0;
			normal_y      <= fc.hit ? nyv : '0;
			order_swapped <= fc.swapped;
		end
	end

	a_miss_clear: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !hit |-> penetration == 32'd0 && normal_x == 16'sd0 && normal_y == 16'sd0)
		else $error("miss response carries nonzero payload");

	a_hit_normal: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> normal_x != 16'sd0 || normal_y != 16'sd0)
		else $error("hit response with zero normal");

	a_normal_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && hit |-> normal_x <= ONE_Q14 && normal_x >= -ONE_Q14 &&
			normal_y <= ONE_Q14 && normal_y >= -ONE_Q14)
		else $error("normal component out of range");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |-> req_stall)
		else $error("request taken while response held");

endmodule
`default_nettype wire

[tb/collision_2d_circle_box_narrowphase_top_test.sv]
`timescale 1ns / 100ps
`default_nettype none
module collision_2d_circle_box_narrowphase_top_test;
	import cnp_pkg::*;

	localparam int LATENCY = 53;

	typedef struct {
		bit               a_box;
		bit signed [31:0] ax;
		bit signed [31:0] ay;
		bit [30:0]        aw;
		bit [30:0]        ah;
		bit               b_box;
		bit signed [31:0] bx;
		bit signed [31:0] by;
		bit [30:0]        bw;
		bit [30:0]        bh;
	} pair_t;

	typedef struct {
		bit               hit;
		bit [31:0]        pen;
		bit signed [15:0] nx;
		bit signed [15:0] ny;
		bit               swapped;
	} contact_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	logic first_is_box = 1'b0;
	logic signed [31:0] first_x = '0;
	logic signed [31:0] first_y = '0;
	logic [30:0] first_extent_w = '0;
	logic [30:0] first_extent_h = '0;
	logic second_is_box = 1'b0;
	logic signed [31:0] second_x = '0;
	logic signed [31:0] second_y = '0;
	logic [30:0] second_extent_w = '0;
	logic [30:0] second_extent_h = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	logic hit;
	logic [31:0] penetration;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic order_swapped;

	contact_t pending_contacts[$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	collision_2d_circle_box_narrowphase_top u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall),
		.first_is_box(first_is_box), .first_x(first_x), .first_y(first_y),
		.first_extent_w(first_extent_w), .first_extent_h(first_extent_h),
		.second_is_box(second_is_box), .second_x(second_x), .second_y(second_y),
		.second_extent_w(second_extent_w), .second_extent_h(second_extent_h),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
		.hit(hit), .penetration(penetration), .normal_x(normal_x),
		.normal_y(normal_y), .order_swapped(order_swapped)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	function automatic longint unit_comp(input longint d, input longint unsigned s);
		longint unsigned mag;
		longint unsigned q;
		mag = d < 0 ? -d : d;
		q = (mag * 16384 + s / 2) / s;
		if (q > 16384)
			q = 16384;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic bit within_radius(input longint dx, input longint dy,
			input longint unsigned r, output longint unsigned s,
			output longint nx, output longint ny);
		longint unsigned mx;
		longint unsigned my;
		longint unsigned sx;
		longint unsigned sum;
		s = 0;
		nx = 0;
		ny = 0;
		mx = dx < 0 ? -dx : dx;
		my = dy < 0 ? -dy : dy;
		if (mx >= r || my >= r)
			return 1'b0;
		sx = mx * mx;
		sum = sx + my * my;
		if (sum < sx || sum >= r * r)
			return 1'b0;
		s = int_sqrt(sum);
		if (sum == 0) begin
			nx = 16384;
		end else begin
			nx = unit_comp(dx, s);
			ny = unit_comp(dy, s);
		end
		return 1'b1;
	endfunction

	function automatic contact_t predict_contact(input pair_t p);
		contact_t c;
		longint ax, ay, bx, by, aw, ah, bw, bh;
		longint aL, aR, aB, aT, bL, bR, bB, bT, px, py;
		longint cx, cy, kx, ky, kw, kh, lo, hi, nx, ny;
		longint unsigned s, r, pen;
		bit h;
		ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
		aw = p.aw; ah = p.ah; bw = p.bw; bh = p.bh;
		h = 0; pen = 0; nx = 0; ny = 0;
		c.swapped = 0;
		if (!p.a_box && !p.b_box) begin
			r = aw + bw;
			h = within_radius(bx - ax, by - ay, r, s, nx, ny);
			if (h)
				pen = r - s;
		end else if (p.a_box && p.b_box) begin
			aL = 2 * ax - aw; aR = 2 * ax + aw; aB = 2 * ay - ah; aT = 2 * ay + ah;
			bL = 2 * bx - bw; bR = 2 * bx + bw; bB = 2 * by - bh; bT = 2 * by + bh;
			if (!(aR < bL || aL > bR || aT < bB || aB > bT)) begin
				px = (aR - bL) < (bR - aL) ? (aR - bL) : (bR - aL);
				py = (aT - bB) < (bT - aB) ? (aT - bB) : (bT - aB);
				h = 1;
				pen = (px < py ? px : py) >> 1;
				if (px < py)
					nx = ax < bx ? -16384 : 16384;
				else
					ny = ay < by ? -16384 : 16384;
			end
		end else begin
			c.swapped = p.a_box;
			if (p.a_box) begin
				cx = bx; cy = by; r = bw; kx = ax; ky = ay; kw = aw; kh = ah;
			end else begin
				cx = ax; cy = ay; r = aw; kx = bx; ky = by; kw = bw; kh = bh;
			end
			cx *= 2; cy *= 2; kx *= 2; ky *= 2;
			lo = kx - kw; hi = kx + kw;
			px = cx < hi ? cx : hi;
			if (px < lo)
				px = lo;
			lo = ky - kh; hi = ky + kh;
			py = cy < hi ? cy : hi;
			if (py < lo)
				py = lo;
			r = r * 2;
			h = within_radius(cx - px, cy - py, r, s, nx, ny);
			if (h)
				pen = (r - s) >> 1;
		end
		if (!h) begin
			pen = 0; nx = 0; ny = 0;
		end
		c.hit = h;
		c.pen = pen[31:0];
		c.nx = nx[15:0];
		c.ny = ny[15:0];
		return c;
	endfunction

	always @(posedge clk)
		rsp_stall <= arst_n && ($urandom_range(0, 99) < recv_idle_pct);

	always @(posedge clk) begin
		contact_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (pending_contacts.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected response hit=%0d pen=%0h", hit, penetration);
			end else begin
				want = pending_contacts.pop_front();
				if (hit !== want.hit || penetration !== want.pen || normal_x !== want.nx
						|| normal_y !== want.ny || order_swapped !== want.swapped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %0d %0h %0d %0d %0d got %0d %0h %0d %0d %0d",
							want.hit, want.pen, want.nx, want.ny, want.swapped,
							hit, penetration, normal_x, normal_y, order_swapped);
				end
			end
		end
	end

	task automatic send_request(input pair_t p);
		int gap;
		gap = ($urandom_range(0, 99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		first_is_box <= p.a_box; first_x <= p.ax; first_y <= p.ay;
		first_extent_w <= p.aw; first_extent_h <= p.ah;
		second_is_box <= p.b_box; second_x <= p.bx; second_y <= p.by;
		second_extent_w <= p.bw; second_extent_h <= p.bh;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		pending_contacts.push_back(predict_contact(p));
	endtask

	task automatic drain;
		req_valid <= 1'b0;
		while (pending_contacts.size() != 0)
			@(posedge clk);
	endtask

	function automatic pair_t shape_pair(input bit a_box, input int ax, input int ay,
			input int aw, input int ah, input bit b_box, input int bx, input int by,
			input int bw, input int bh);
		pair_t p;
		p.a_box = a_box; p.ax = ax; p.ay = ay; p.aw = 31'(aw); p.ah = 31'(ah);
		p.b_box = b_box; p.bx = bx; p.by = by; p.bw = 31'(bw); p.bh = 31'(bh);
		return p;
	endfunction

	task automatic test_directed;
		localparam int U = 1 << 16;
		localparam int MAXC = 32'h7fffffff;
		localparam int MINC = 32'h80000000;
		localparam int MAXE = 32'h7fffffff;
		// circles: touching, just overlapping, same centre, zero radius
		send_request(shape_pair(0, 0, 0, U, 0, 0, 2 * U, 0, U, 0));
		send_request(shape_pair(0, 0, 0, U, 0, 0, 2 * U - 1, 0, U, 0));
		send_request(shape_pair(0, 5 * U, -3 * U, U, 7, 0, 5 * U, -3 * U, 3 * U, 9));
		send_request(shape_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		send_request(shape_pair(0, U, U, U, 0, 0, 0, 0, U, 0));
		// boxes: touching edges, overlap on x, overlap on y, both orders
		send_request(shape_pair(1, 0, 0, 2 * U, 2 * U, 1, 2 * U, 0, 2 * U, 2 * U));
		send_request(shape_pair(1, 0, 0, 4 * U, 8 * U, 1, U, 0, 4 * U, 8 * U));
		send_request(shape_pair(1, U, 0, 4 * U, 8 * U, 1, 0, 0, 4 * U, 8 * U));
		send_request(shape_pair(1, 0, 0, 8 * U, 4 * U, 1, 0, U, 8 * U, 4 * U));
		send_request(shape_pair(1, 0, U, 8 * U, 4 * U, 1, 0, 0, 8 * U, 4 * U));
		send_request(shape_pair(1, 0, 0, U, U, 1, 3 * U, 0, U, U));
		// circle and box, both orders, hit and miss
		send_request(shape_pair(0, 0, 0, U, 0, 1, 0, 0, 2 * U, 2 * U));
		send_request(shape_pair(1, 0, 0, 2 * U, 2 * U, 0, U + U / 2, U + U / 2, U, 0));
		send_request(shape_pair(1, 0, 0, 2 * U, 2 * U, 0, 9 * U, 0, U, 0));
		send_request(shape_pair(0, 2 * U, 0, U, 0, 1, 0, 0, 2 * U, 2 * U));
		send_request(shape_pair(0, 0, 0, 0, 0, 1, 0, 0, 2 * U, 2 * U));
		// extremes of every field
		send_request(shape_pair(0, MINC, MINC, MAXE, MAXE, 0, MAXC, MAXC, MAXE, MAXE));
		send_request(shape_pair(0, MAXC, MINC, MAXE, 0, 0, MAXC, MINC, MAXE, 0));
		send_request(shape_pair(1, MINC, MAXC, MAXE, MAXE, 1, MAXC, MINC, MAXE, MAXE));
		send_request(shape_pair(1, MAXC, MAXC, MAXE, MAXE, 0, MINC, MINC, MAXE, 0));
		send_request(shape_pair(0, MINC, MAXC, MAXE, MAXE, 1, MINC, MAXC, 0, 0));
		send_request(shape_pair(1, MAXC, MAXC, 0, 0, 1, MAXC, MAXC, 0, 0));
		// hold until everything is back
		drain();
	endtask

	function automatic pair_t random_pair;
		pair_t p;
		int spread;
		p.a_box = 1'($urandom_range(0, 1));
		p.b_box = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 99) < 20) begin
			p.ax = $urandom; p.ay = $urandom; p.bx = $urandom; p.by = $urandom;
			p.aw = 31'($urandom); p.ah = 31'($urandom);
			p.bw = 31'($urandom); p.bh = 31'($urandom);
		end else begin
			spread = 1 << $urandom_range(8, 22);
			p.ax = $urandom; p.ay = $urandom;
			p.bx = p.ax + $signed($urandom_range(0, 2 * spread)) - spread;
			p.by = p.ay + $signed($urandom_range(0, 2 * spread)) - spread;
			p.aw = 31'($urandom_range(0, spread));
			p.ah = 31'($urandom_range(0, spread));
			p.bw = 31'($urandom_range(0, spread));
			p.bh = 31'($urandom_range(0, spread));
			if ($urandom_range(0, 9) == 0) begin
				p.bx = p.ax; p.by = p.ay;
			end
		end
		return p;
	endfunction

	task automatic test_random(input int count, input int tx_pct, input int rx_pct);
		send_idle_pct = tx_pct;
		recv_idle_pct = rx_pct;
		repeat (count)
			send_request(random_pair());
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(480, 22, 81);
		drain();
		test_random(480, 81, 22);
		test_random(480, 0, 0);
		drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
`default_nettype wire
